### design/set_assoc_writeback_cache_assert.svh
// assertion macros shared by the cache rtl
`ifndef SET_ASSOC_WRITEBACK_CACHE_ASSERT_SVH
`define SET_ASSOC_WRITEBACK_CACHE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SAWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define SAWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) \
    else $error(msg);
`else
`define SAWC_ASSERT(label, prop, msg)
`define SAWC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### design/sawc_pkg.sv
`timescale 1ns / 1ps
package sawc_pkg;

  localparam int unsigned BLOCK_WORDS   = 4;
  localparam int unsigned WORD_SEL_BITS = 2;
  localparam int unsigned COUNT_BITS    = 32;
  localparam int unsigned RANK_BITS     = 3;
  localparam logic [RANK_BITS-1:0] RANK_MAX = '1;
  localparam int unsigned CFG_BITS      = 2;
  localparam int unsigned OP_BITS       = 2;
  localparam int unsigned STATUS_BITS   = 2;
  // sequencer count: up to eight ways, or four words plus the step that collects the last store read
  localparam int unsigned SEQ_BITS      = 3;
  localparam int unsigned SC_W          = SEQ_BITS + 1;

  typedef enum logic [OP_BITS-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2
  } op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_HIT     = 2'd0,
    STAT_MISS    = 2'd1,
    STAT_FILL    = 2'd2,
    STAT_IGNORED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_HIT,
    ST_MISS,
    ST_WB,
    ST_FILL,
    ST_DONE
  } state_e;

endpackage

### design/sawc_ifs.sv
`timescale 1ns / 1ps
interface sawc_in_if
  import sawc_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = 16,
  parameter int unsigned WORD_BITS    = 32
);
  logic                           valid;
  logic                           ready;
  logic [OP_BITS-1:0]             operation;
  logic [ADDRESS_BITS-1:0]        address;
  logic signed [WORD_BITS-1:0]    write_data;
  logic signed [WORD_BITS-1:0]    fill_word0;
  logic signed [WORD_BITS-1:0]    fill_word1;
  logic signed [WORD_BITS-1:0]    fill_word2;
  logic signed [WORD_BITS-1:0]    fill_word3;

  modport source (
    output valid, operation, address, write_data,
    output fill_word0, fill_word1, fill_word2, fill_word3,
    input  ready
  );
  modport sink (
    input  valid, operation, address, write_data,
    input  fill_word0, fill_word1, fill_word2, fill_word3,
    output ready
  );
endinterface

interface sawc_out_if
  import sawc_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = 16,
  parameter int unsigned WORD_BITS    = 32
);
  logic                                    valid;
  logic                                    ready;
  logic [STATUS_BITS-1:0]                  status;
  logic signed [WORD_BITS-1:0]             read_data;
  logic [ADDRESS_BITS-WORD_SEL_BITS-1:0]   fill_block_address;
  logic                                    writeback_valid;
  logic [ADDRESS_BITS-WORD_SEL_BITS-1:0]   writeback_block_address;
  logic signed [WORD_BITS-1:0]             writeback_word0;
  logic signed [WORD_BITS-1:0]             writeback_word1;
  logic signed [WORD_BITS-1:0]             writeback_word2;
  logic signed [WORD_BITS-1:0]             writeback_word3;
  logic [COUNT_BITS-1:0]                   hit_count;
  logic [COUNT_BITS-1:0]                   miss_count;

  modport source (
    output valid, status, read_data, fill_block_address, writeback_valid,
    output writeback_block_address, writeback_word0, writeback_word1,
    output writeback_word2, writeback_word3, hit_count, miss_count,
    input  ready
  );
  modport sink (
    input  valid, status, read_data, fill_block_address, writeback_valid,
    input  writeback_block_address, writeback_word0, writeback_word1,
    input  writeback_word2, writeback_word3, hit_count, miss_count,
    output ready
  );
endinterface

### design/sawc_div.sv
`timescale 1ns / 1ps
module sawc_div #(
  parameter int unsigned DIVIDEND_W = 14,
  parameter int unsigned DIVISOR_W  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic [DIVISOR_W-1:0]  remainder_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // restoring radix-2 step: one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    diff  = trial - {1'b0, divisor_i};
    fits  = trial >= {1'b0, divisor_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

### design/set_assoc_writeback_cache.sv
`timescale 1ns / 1ps
// write-back, write-allocate lru cache of LINE_COUNT four-word lines, one item at a time.
// in_ch.ready is high only while the block is idle. a read or write first splits the block
// address into set and tag in a shared radix-2 divider, then walks the ways of the set
// through one tag comparator, one way per cycle, then does the hit or miss update in its
// own state and hands the result over. a miss that evicts a dirty line first reads the
// four victim words out of the line store one per cycle. a fill writes its four words one
// per cycle. the output register lets the next item be accepted while the last result
// still waits to be taken. the line store has no reset; only lines marked valid are ever
// read from it.
`include "set_assoc_writeback_cache_assert.svh"
module set_assoc_writeback_cache
  import sawc_pkg::*;
#(
  parameter int unsigned LINE_COUNT   = 8,
  parameter int unsigned ADDRESS_BITS = 16,
  parameter int unsigned WORD_BITS    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  sawc_in_if.sink             in_ch,
  sawc_out_if.source          out_ch
);

  localparam int unsigned LINE_W    = $clog2(LINE_COUNT);
  localparam int unsigned LINE_CW   = $clog2(LINE_COUNT + 1);
  localparam int unsigned SUM_W     = LINE_CW + 1;
  localparam int unsigned BLK_W     = ADDRESS_BITS - WORD_SEL_BITS;
  localparam int unsigned MEM_DEPTH = LINE_COUNT * BLOCK_WORDS;
  localparam int unsigned MEM_AW    = LINE_W + WORD_SEL_BITS;
  localparam int unsigned WAYS0     = 1;
  localparam int unsigned WAYS1     = (LINE_COUNT < 2) ? LINE_COUNT : 2;
  localparam int unsigned WAYS2     = (LINE_COUNT < 4) ? LINE_COUNT : 4;
  localparam int unsigned WAYS3     = (LINE_COUNT < 8) ? LINE_COUNT : 8;
  localparam int unsigned SETS0     = LINE_COUNT / WAYS0;
  localparam int unsigned SETS1     = LINE_COUNT / WAYS1;
  localparam int unsigned SETS2     = LINE_COUNT / WAYS2;
  localparam int unsigned SETS3     = LINE_COUNT / WAYS3;

  // control state
  state_e                    state_q, state_d;
  logic [CFG_BITS-1:0]       cfg_q;
  logic [SEQ_BITS-1:0]       seq_q;
  logic                      out_valid_q;
  logic                      valid_q [LINE_COUNT];
  logic                      dirty_q [LINE_COUNT];
  logic [BLK_W-1:0]          tag_q   [LINE_COUNT];
  logic [RANK_BITS-1:0]      rank_q  [LINE_COUNT];
  logic [COUNT_BITS-1:0]     hits_q, misses_q;
  logic                      pend_q, pend_wr_q;
  logic [LINE_W-1:0]         pend_line_q;
  logic [WORD_SEL_BITS-1:0]  pend_word_q;

  // item and work registers
  logic [OP_BITS-1:0]        op_q;
  logic [ADDRESS_BITS-1:0]   addr_q;
  logic [WORD_BITS-1:0]      wdata_q;
  logic [WORD_BITS-1:0]      fill_q [BLOCK_WORDS];
  logic [WORD_BITS-1:0]      pend_data_q;
  logic [LINE_W-1:0]         base_q;
  logic [LINE_W-1:0]         hit_line_q, inv_line_q, best_line_q;
  logic                      inv_found_q;
  logic [RANK_BITS-1:0]      best_rank_q;
  status_e                   status_q;
  logic                      rd_mem_q;
  logic [WORD_BITS-1:0]      rd_q;
  logic                      wb_valid_q;
  logic [BLK_W-1:0]          wb_addr_q;
  logic [WORD_BITS-1:0]      wb_word_q [BLOCK_WORDS];

  // output register
  status_e                   o_status_q;
  logic [WORD_BITS-1:0]      o_rd_q;
  logic [BLK_W-1:0]          o_fill_addr_q;
  logic                      o_wb_valid_q;
  logic [BLK_W-1:0]          o_wb_addr_q;
  logic [WORD_BITS-1:0]      o_wb_word_q [BLOCK_WORDS];
  logic [COUNT_BITS-1:0]     o_hits_q, o_misses_q;

  // line store
  logic [WORD_BITS-1:0]      mem_q [MEM_DEPTH];
  logic [WORD_BITS-1:0]      rdata_q;

  logic                      in_ready;
  logic                      accept;
  logic                      div_start, div_done;
  logic [BLK_W-1:0]          div_quo;
  logic [LINE_CW-1:0]        div_rem;
  logic [LINE_CW-1:0]        ways_v, sets_v;
  logic [LINE_W-1:0]         fill_base;
  logic [LINE_W-1:0]         scan_line;
  logic                      scan_last, tag_hit;
  logic [LINE_W-1:0]         victim_line;
  logic                      miss_wb;
  logic                      mem_we, mem_re;
  logic [MEM_AW-1:0]         mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0]      mem_wdata;
  logic                      touch_en, touch_fresh;
  logic [LINE_W-1:0]         touch_line;
  logic [RANK_BITS-1:0]      touch_old;
  logic                      in_set [LINE_COUNT];
  logic                      out_load;
  logic [WORD_BITS-1:0]      in_fill [BLOCK_WORDS];

  assign in_fill[0] = in_ch.fill_word0;
  assign in_fill[1] = in_ch.fill_word1;
  assign in_fill[2] = in_ch.fill_word2;
  assign in_fill[3] = in_ch.fill_word3;

  assign accept = in_ready && in_ch.valid;

  // geometry of the current setting
  always_comb begin
    unique case (cfg_q)
      2'd0: begin
        ways_v    = LINE_CW'(WAYS0);
        sets_v    = LINE_CW'(SETS0);
        fill_base = pend_line_q;
      end
      2'd1: begin
        ways_v    = LINE_CW'(WAYS1);
        sets_v    = LINE_CW'(SETS1);
        fill_base = LINE_W'((pend_line_q / WAYS1) * WAYS1);
      end
      2'd2: begin
        ways_v    = LINE_CW'(WAYS2);
        sets_v    = LINE_CW'(SETS2);
        fill_base = LINE_W'((pend_line_q / WAYS2) * WAYS2);
      end
      default: begin
        ways_v    = LINE_CW'(WAYS3);
        sets_v    = LINE_CW'(SETS3);
        fill_base = LINE_W'((pend_line_q / WAYS3) * WAYS3);
      end
    endcase
  end

  sawc_div #(
    .DIVIDEND_W (BLK_W),
    .DIVISOR_W  (LINE_CW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (in_ch.address[ADDRESS_BITS-1:WORD_SEL_BITS]),
    .divisor_i   (sets_v),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // way walk through the shared tag comparator
  always_comb begin
    scan_line   = base_q + LINE_W'(seq_q);
    scan_last   = (SC_W'(seq_q) + 1'b1) == SC_W'(ways_v);
    tag_hit     = valid_q[scan_line] && (tag_q[scan_line] == div_quo);
    victim_line = inv_found_q ? inv_line_q : best_line_q;
    miss_wb     = !inv_found_q && dirty_q[victim_line];
    touch_old   = rank_q[touch_line];
    for (int j = 0; j < LINE_COUNT; j++) begin
      in_set[j] = (SUM_W'(j) >= SUM_W'(base_q)) &&
                  (SUM_W'(j) < SUM_W'(base_q) + SUM_W'(ways_v));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready    = 1'b0;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = {hit_line_q, addr_q[WORD_SEL_BITS-1:0]};
    mem_raddr   = {hit_line_q, addr_q[WORD_SEL_BITS-1:0]};
    mem_wdata   = wdata_q;
    touch_en    = 1'b0;
    touch_fresh = 1'b0;
    touch_line  = hit_line_q;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          priority if ((in_ch.operation == OP_READ || in_ch.operation == OP_WRITE)
                       && !pend_q) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else if (in_ch.operation == OP_FILL && pend_q) begin
            state_d = ST_FILL;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (tag_hit) state_d = ST_HIT;
        else if (scan_last) state_d = ST_MISS;
        else state_d = ST_SCAN;
      end
      ST_HIT: begin
        touch_en = 1'b1;
        if (op_q == OP_WRITE) begin
          mem_we = 1'b1;
        end else begin
          mem_re = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_MISS: begin
        state_d = miss_wb ? ST_WB : ST_DONE;
      end
      ST_WB: begin
        // read word k while word k-1 lands in rdata_q
        mem_re    = (seq_q < SEQ_BITS'(BLOCK_WORDS));
        mem_raddr = {pend_line_q, seq_q[WORD_SEL_BITS-1:0]};
        if (seq_q == SEQ_BITS'(BLOCK_WORDS)) state_d = ST_DONE;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = {pend_line_q, seq_q[WORD_SEL_BITS-1:0]};
        mem_wdata = (pend_wr_q && seq_q[WORD_SEL_BITS-1:0] == pend_word_q) ?
                    pend_data_q : fill_q[seq_q[WORD_SEL_BITS-1:0]];
        if (seq_q == SEQ_BITS'(BLOCK_WORDS - 1)) begin
          touch_en    = 1'b1;
          touch_fresh = 1'b1;
          touch_line  = pend_line_q;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ch.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
      valid_q     <= '{default: 1'b0};
      dirty_q     <= '{default: 1'b0};
      tag_q       <= '{default: '0};
      rank_q      <= '{default: '0};
      hits_q      <= '0;
      misses_q    <= '0;
      pend_q      <= 1'b0;
      pend_wr_q   <= 1'b0;
      pend_line_q <= '0;
      pend_word_q <= '0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_data_i;

      if (out_load) out_valid_q <= 1'b1;
      else if (out_ch.ready) out_valid_q <= 1'b0;

      if (state_q == ST_SCAN || state_q == ST_WB || state_q == ST_FILL) begin
        seq_q <= seq_q + 1'b1;
      end else begin
        seq_q <= '0;
      end

      // lru aging: other valid lines of the set ranked lower than the touched one (all of them on a fill) age one step
      if (touch_en) begin
        for (int j = 0; j < LINE_COUNT; j++) begin
          if (LINE_W'(j) != touch_line && valid_q[j] && in_set[j] &&
              (touch_fresh || rank_q[j] < touch_old) && rank_q[j] != RANK_MAX) begin
            rank_q[j] <= rank_q[j] + 1'b1;
          end
        end
        rank_q[touch_line] <= '0;
      end

      if (state_q == ST_HIT) begin
        if (op_q == OP_WRITE) dirty_q[hit_line_q] <= 1'b1;
        if (hits_q != '1) hits_q <= hits_q + 1'b1;
      end

      if (state_q == ST_MISS) begin
        valid_q[victim_line] <= 1'b0;
        dirty_q[victim_line] <= 1'b0;
        tag_q[victim_line]   <= div_quo;
        pend_q      <= 1'b1;
        pend_wr_q   <= (op_q == OP_WRITE);
        pend_line_q <= victim_line;
        pend_word_q <= addr_q[WORD_SEL_BITS-1:0];
        if (misses_q != '1) misses_q <= misses_q + 1'b1;
      end

      if (state_q == ST_FILL && seq_q == SEQ_BITS'(BLOCK_WORDS - 1)) begin
        valid_q[pend_line_q] <= 1'b1;
        dirty_q[pend_line_q] <= pend_wr_q;
        pend_q               <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= in_ch.operation;
      addr_q     <= in_ch.address;
      wdata_q    <= in_ch.write_data;
      for (int k = 0; k < BLOCK_WORDS; k++) fill_q[k] <= in_fill[k];
      rd_q       <= '0;
      rd_mem_q   <= 1'b0;
      wb_valid_q <= 1'b0;
      status_q   <= STAT_IGNORED;
      if (in_ch.operation == OP_FILL && pend_q) begin
        base_q   <= fill_base;
        status_q <= STAT_FILL;
        if (!pend_wr_q) rd_q <= in_fill[pend_word_q];
      end
    end

    if (state_q == ST_DIV && div_done) begin
      base_q      <= LINE_W'(div_rem * ways_v);
      inv_found_q <= 1'b0;
    end

    if (state_q == ST_SCAN) begin
      if (tag_hit) hit_line_q <= scan_line;
      if (!valid_q[scan_line] && !inv_found_q) begin
        inv_found_q <= 1'b1;
        inv_line_q  <= scan_line;
      end
      // strictly greater keeps the lowest way on a tie
      if (seq_q == '0 || rank_q[scan_line] > best_rank_q) begin
        best_rank_q <= rank_q[scan_line];
        best_line_q <= scan_line;
      end
    end

    if (state_q == ST_HIT) begin
      status_q <= STAT_HIT;
      rd_mem_q <= (op_q == OP_READ);
    end

    if (state_q == ST_MISS) begin
      status_q    <= STAT_MISS;
      wb_valid_q  <= miss_wb;
      wb_addr_q   <= BLK_W'(tag_q[victim_line] * sets_v + div_rem);
      pend_data_q <= (op_q == OP_WRITE) ? wdata_q : '0;
    end

    if (state_q == ST_WB && seq_q != '0) begin
      wb_word_q[WORD_SEL_BITS'(seq_q - 1'b1)] <= rdata_q;
    end

    if (out_load) begin
      o_status_q    <= status_q;
      o_rd_q        <= rd_mem_q ? rdata_q : rd_q;
      o_fill_addr_q <= (status_q == STAT_MISS) ? addr_q[ADDRESS_BITS-1:WORD_SEL_BITS] : '0;
      o_wb_valid_q  <= wb_valid_q;
      o_wb_addr_q   <= wb_valid_q ? wb_addr_q : '0;
      for (int k = 0; k < BLOCK_WORDS; k++) begin
        o_wb_word_q[k] <= wb_valid_q ? wb_word_q[k] : '0;
      end
      o_hits_q      <= hits_q;
      o_misses_q    <= misses_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  assign in_ch.ready                     = in_ready;
  assign out_ch.valid                    = out_valid_q;
  assign out_ch.status                   = o_status_q;
  assign out_ch.read_data                = o_rd_q;
  assign out_ch.fill_block_address       = o_fill_addr_q;
  assign out_ch.writeback_valid          = o_wb_valid_q;
  assign out_ch.writeback_block_address  = o_wb_addr_q;
  assign out_ch.writeback_word0          = o_wb_word_q[0];
  assign out_ch.writeback_word1          = o_wb_word_q[1];
  assign out_ch.writeback_word2          = o_wb_word_q[2];
  assign out_ch.writeback_word3          = o_wb_word_q[3];
  assign out_ch.hit_count                = o_hits_q;
  assign out_ch.miss_count               = o_misses_q;

  `SAWC_ASSERT(a_wb_only_on_miss, out_ch.valid && out_ch.writeback_valid |-> out_ch.status == STAT_MISS, "writeback reported outside a miss")
  `SAWC_ASSERT(a_pending_line_invalid, pend_q && state_q == ST_IDLE |-> !valid_q[pend_line_q], "line awaiting fill is still valid")
  `SAWC_ASSERT(a_div_done_in_div, div_done |-> state_q == ST_DIV, "divider finished outside the split step")
  `SAWC_ASSERT_NEXT(a_hits_step, 1'b1, (hits_q == $past(hits_q)) || (hits_q == $past(hits_q) + 1'b1), "hit total moved by more than one")

endmodule
